### rtl/pci_pkg.sv
// shared types, widths and helpers of the particle contact impulse core
`timescale 1ns / 1ps
package pci_pkg;

  localparam int VEL_W  = 32;  // signed velocity
  localparam int MASS_W = 31;  // unsigned inverse mass
  localparam int NRM_W  = 18;  // signed normal component
  localparam int BNC_W  = 17;  // unsigned restitution
  localparam int REL_W  = VEL_W + 1;
  localparam int PROD_W = REL_W + NRM_W;
  localparam int DOT_W  = PROD_W + 1;
  localparam int TOT_W  = MASS_W + 1;
  localparam int K_W    = 25;  // one plus restitution, room for the widest fraction
  localparam int LO_W   = 24;  // split point of the delta multiplier
  localparam int IMP_W  = 31;  // impulse, saturated to the signed range
  localparam int PR_W   = NRM_W + IMP_W + 1;
  localparam int MP_W   = 2 * VEL_W;
  localparam int SAT_W  = 72;

  localparam logic [IMP_W-1:0]        IMP_MAX = '1;
  localparam logic signed [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
  localparam logic signed [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};

  typedef enum logic [1:0] {
    OUT_APPLIED    = 2'd0,
    OUT_SEPARATING = 2'd1,
    OUT_INF_MASS   = 2'd2
  } pci_outcome_e;

  typedef struct packed {
    logic signed [VEL_W-1:0] v1x;
    logic signed [VEL_W-1:0] v1y;
    logic signed [VEL_W-1:0] v2x;
    logic signed [VEL_W-1:0] v2y;
    logic [MASS_W-1:0]       m1;
    logic [MASS_W-1:0]       m2;
    logic signed [NRM_W-1:0] nx;
    logic signed [NRM_W-1:0] ny;
    logic [BNC_W-1:0]        e;
    logic                    two;
    pci_outcome_e            outcome;
  } pci_ctx_t;

  // clamp a wide signed value to the signed 32 bit range
  function automatic logic signed [VEL_W-1:0] sat32(input logic signed [SAT_W-1:0] x);
    if ((&x[SAT_W-1:VEL_W-1]) || !(|x[SAT_W-1:VEL_W-1])) begin
      return x[VEL_W-1:0];
    end
    return x[SAT_W-1] ? VEL_MIN : VEL_MAX;
  endfunction

endpackage

### rtl/pci_front.sv
// front stages: relative velocity, dot product, early exit and delta product
`timescale 1ns / 1ps
module pci_front #(
  parameter int FRAC_BITS = 16,
  localparam int DIV_W = pci_pkg::DOT_W - 1 - FRAC_BITS + pci_pkg::K_W
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  logic                        valid_i,
  input  pci_pkg::pci_ctx_t           ctx_i,
  output logic                        valid_o,
  output pci_pkg::pci_ctx_t           ctx_o,
  output logic [pci_pkg::TOT_W-1:0]   total_o,
  output logic [DIV_W-1:0]            dividend_o
);
  import pci_pkg::*;

  localparam int NS_W = DOT_W - 1 - FRAC_BITS;
  localparam int HI_W = NS_W - LO_W;
  localparam int NSTG = 6;
  localparam logic [DIV_W-1:0] FRAC_MASK = (DIV_W'(1) << FRAC_BITS) - DIV_W'(1);

  logic [NSTG-1:0]           valid_q;
  pci_ctx_t                  ctx_q [NSTG];
  logic [TOT_W-1:0]          total_q [NSTG];

  logic signed [REL_W-1:0]   rel_x_d, rel_y_d, rel_x_q, rel_y_q;
  logic [TOT_W-1:0]          total_d;
  logic signed [PROD_W-1:0]  prod_x_d, prod_y_d, prod_x_q, prod_y_q;
  logic signed [DOT_W-1:0]   dot_d, dot_q;
  logic signed [DOT_W-1:0]   sep_s, neg_s;
  logic [NS_W-1:0]           negsep_d, negsep_q;
  pci_ctx_t                  ctx4_d;
  logic [K_W-1:0]            k_d;
  logic [LO_W+K_W-1:0]       plo_d, plo_q;
  logic [HI_W+K_W-1:0]       phi_d, phi_q;
  logic [DIV_W-1:0]          dividend_d, dividend_q;

  always_comb begin
    // relative velocity, second particle taken as zero when absent
    rel_x_d = ctx_i.two ? (REL_W'(ctx_i.v1x) - REL_W'(ctx_i.v2x)) : REL_W'(ctx_i.v1x);
    rel_y_d = ctx_i.two ? (REL_W'(ctx_i.v1y) - REL_W'(ctx_i.v2y)) : REL_W'(ctx_i.v1y);
    total_d = TOT_W'(ctx_i.m1) + (ctx_i.two ? TOT_W'(ctx_i.m2) : '0);

    prod_x_d = rel_x_q * ctx_q[0].nx;
    prod_y_d = rel_y_q * ctx_q[0].ny;

    dot_d = DOT_W'(prod_x_q) + DOT_W'(prod_y_q);

    sep_s    = dot_q >>> FRAC_BITS;
    neg_s    = -sep_s;
    negsep_d = neg_s[NS_W-1:0];
    ctx4_d   = ctx_q[2];
    if (!dot_q[DOT_W-1] && (dot_q != '0)) begin
      ctx4_d.outcome = OUT_SEPARATING;
    end else if (total_q[2] == '0) begin
      ctx4_d.outcome = OUT_INF_MASS;
    end else begin
      ctx4_d.outcome = OUT_APPLIED;
    end

    // delta = negsep * (1 + e), in two partial products
    k_d   = (K_W'(1) << FRAC_BITS) + K_W'(ctx_q[3].e);
    plo_d = negsep_q[LO_W-1:0] * k_d;
    phi_d = negsep_q[NS_W-1:LO_W] * k_d;

    // delta shifted back up, fraction bits dropped by the floor
    dividend_d = ((DIV_W'(phi_q) << LO_W) + DIV_W'(plo_q)) & ~FRAC_MASK;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv_i) begin
      valid_q <= {valid_q[NSTG-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ctx_q[0]   <= ctx_i;
      total_q[0] <= total_d;
      rel_x_q    <= rel_x_d;
      rel_y_q    <= rel_y_d;

      ctx_q[1]   <= ctx_q[0];
      total_q[1] <= total_q[0];
      prod_x_q   <= prod_x_d;
      prod_y_q   <= prod_y_d;

      ctx_q[2]   <= ctx_q[1];
      total_q[2] <= total_q[1];
      dot_q      <= dot_d;

      ctx_q[3]   <= ctx4_d;
      total_q[3] <= total_q[2];
      negsep_q   <= negsep_d;

      ctx_q[4]   <= ctx_q[3];
      total_q[4] <= total_q[3];
      plo_q      <= plo_d;
      phi_q      <= phi_d;

      ctx_q[5]   <= ctx_q[4];
      total_q[5] <= total_q[4];
      dividend_q <= dividend_d;
    end
  end

  assign valid_o    = valid_q[NSTG-1];
  assign ctx_o      = ctx_q[NSTG-1];
  assign total_o    = total_q[NSTG-1];
  assign dividend_o = dividend_q;

endmodule

### rtl/pci_div.sv
// pipelined restoring divider for the impulse, one quotient bit per stage
`timescale 1ns / 1ps
module pci_div #(
  parameter int FRAC_BITS = 16,
  localparam int DIV_W = pci_pkg::DOT_W - 1 - FRAC_BITS + pci_pkg::K_W
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  logic                        valid_i,
  input  pci_pkg::pci_ctx_t           ctx_i,
  input  logic [pci_pkg::TOT_W-1:0]   total_i,
  input  logic [DIV_W-1:0]            dividend_i,
  output logic                        valid_o,
  output pci_pkg::pci_ctx_t           ctx_o,
  output logic [pci_pkg::IMP_W-1:0]   imp_o
);
  import pci_pkg::*;

  localparam int STEPS = IMP_W;
  localparam int HW    = DIV_W - IMP_W;
  localparam int CW    = (HW > TOT_W) ? HW : TOT_W;

  logic [STEPS:0]     valid_q;
  logic [STEPS:0]     sat_q;
  pci_ctx_t           ctx_q   [STEPS+1];
  logic [TOT_W-1:0]   total_q [STEPS+1];
  logic [TOT_W-1:0]   rem_q   [STEPS+1];
  logic [IMP_W-1:0]   low_q   [STEPS+1];
  logic [IMP_W-1:0]   quo_q   [STEPS+1];

  logic [HW-1:0]      div_hi;
  logic [TOT_W:0]     trial [STEPS];
  logic [STEPS-1:0]   take;

  assign div_hi = dividend_i[DIV_W-1:IMP_W];

  always_comb begin
    for (int i = 0; i < STEPS; i++) begin
      trial[i] = {rem_q[i], low_q[i][IMP_W-1]};
      take[i]  = trial[i] >= {1'b0, total_q[i]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv_i) begin
      valid_q <= {valid_q[STEPS-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      // quotient would not fit in the impulse range: saturate
      sat_q[0]   <= CW'(div_hi) >= CW'(total_i);
      ctx_q[0]   <= ctx_i;
      total_q[0] <= total_i;
      rem_q[0]   <= TOT_W'(div_hi);
      low_q[0]   <= dividend_i[IMP_W-1:0];
      quo_q[0]   <= '0;
      for (int i = 0; i < STEPS; i++) begin
        sat_q[i+1]   <= sat_q[i];
        ctx_q[i+1]   <= ctx_q[i];
        total_q[i+1] <= total_q[i];
        rem_q[i+1]   <= take[i] ? TOT_W'(trial[i] - {1'b0, total_q[i]})
                                : trial[i][TOT_W-1:0];
        low_q[i+1]   <= {low_q[i][IMP_W-2:0], 1'b0};
        quo_q[i+1]   <= {quo_q[i][IMP_W-2:0], take[i]};
      end
    end
  end

  assign valid_o = valid_q[STEPS];
  assign ctx_o   = ctx_q[STEPS];
  assign imp_o   = sat_q[STEPS] ? IMP_MAX : quo_q[STEPS];

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[STEPS] && !sat_q[STEPS] |-> rem_q[STEPS] < total_q[STEPS])
    else $error("divider remainder not below divisor");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv_i |=> $stable(valid_q) && $stable(quo_q[STEPS]) && $stable(sat_q))
    else $error("divider moved while the pipeline was held");

endmodule

### rtl/pci_apply.sv
// back stages: impulse along the normal, mass scaling, velocity update
`timescale 1ns / 1ps
module pci_apply #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              adv_i,
  input  logic                              valid_i,
  input  pci_pkg::pci_ctx_t                 ctx_i,
  input  logic [pci_pkg::IMP_W-1:0]         imp_i,
  output logic                              valid_o,
  output logic signed [pci_pkg::VEL_W-1:0]  new_first_vel_x_o,
  output logic signed [pci_pkg::VEL_W-1:0]  new_first_vel_y_o,
  output logic signed [pci_pkg::VEL_W-1:0]  new_second_vel_x_o,
  output logic signed [pci_pkg::VEL_W-1:0]  new_second_vel_y_o,
  output logic [1:0]                        outcome_o
);
  import pci_pkg::*;

  localparam int NSTG = 5;
  localparam int TW   = MP_W - FRAC_BITS;
  localparam logic signed [MP_W-1:0] ONE_MP = 1;

  logic [NSTG-1:0]           valid_q;
  pci_ctx_t                  ctx_q [NSTG-1];

  logic signed [PR_W-1:0]    pr_d [2];
  logic signed [PR_W-1:0]    pr_q [2];
  logic signed [VEL_W-1:0]   p_d  [2];
  logic signed [VEL_W-1:0]   p_q  [2];
  logic signed [MP_W-1:0]    mp_d [4];
  logic signed [MP_W-1:0]    mp_q [4];
  logic signed [MP_W-1:0]    sh   [4];
  logic signed [TW-1:0]      t_d  [4];
  logic signed [TW-1:0]      t_q  [4];
  logic signed [VEL_W-1:0]   vel  [4];
  logic signed [VEL_W-1:0]   res_d [4];
  logic signed [VEL_W-1:0]   res_q [4];
  pci_outcome_e              outcome_q;
  logic                      applied;

  always_comb begin
    // impulse along the normal
    pr_d[0] = ctx_i.nx * $signed({1'b0, imp_i});
    pr_d[1] = ctx_i.ny * $signed({1'b0, imp_i});
    for (int k = 0; k < 2; k++) begin
      p_d[k] = sat32(SAT_W'(pr_q[k] >>> FRAC_BITS));
    end

    // lanes: first x, first y, second x, second y
    mp_d[0] = p_q[0] * $signed({1'b0, ctx_q[1].m1});
    mp_d[1] = p_q[1] * $signed({1'b0, ctx_q[1].m1});
    mp_d[2] = p_q[0] * $signed({1'b0, ctx_q[1].m2});
    mp_d[3] = p_q[1] * $signed({1'b0, ctx_q[1].m2});

    // second particle floors the negated product: not of floor of (x - 1)
    sh[0] = mp_q[0] >>> FRAC_BITS;
    sh[1] = mp_q[1] >>> FRAC_BITS;
    sh[2] = ~((mp_q[2] - ONE_MP) >>> FRAC_BITS);
    sh[3] = ~((mp_q[3] - ONE_MP) >>> FRAC_BITS);
    for (int k = 0; k < 4; k++) begin
      t_d[k] = sh[k][TW-1:0];
    end

    vel[0]  = ctx_q[3].v1x;
    vel[1]  = ctx_q[3].v1y;
    vel[2]  = ctx_q[3].v2x;
    vel[3]  = ctx_q[3].v2y;
    applied = ctx_q[3].outcome == OUT_APPLIED;
    for (int k = 0; k < 4; k++) begin
      if (applied && ((k < 2) || ctx_q[3].two)) begin
        res_d[k] = sat32(SAT_W'(vel[k]) + SAT_W'(t_q[k]));
      end else begin
        res_d[k] = vel[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv_i) begin
      valid_q <= {valid_q[NSTG-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ctx_q[0] <= ctx_i;
      for (int s = 1; s < NSTG - 1; s++) begin
        ctx_q[s] <= ctx_q[s-1];
      end
      for (int k = 0; k < 2; k++) begin
        pr_q[k] <= pr_d[k];
        p_q[k]  <= p_d[k];
      end
      for (int k = 0; k < 4; k++) begin
        mp_q[k]  <= mp_d[k];
        t_q[k]   <= t_d[k];
        res_q[k] <= res_d[k];
      end
      outcome_q <= ctx_q[3].outcome;
    end
  end

  assign valid_o            = valid_q[NSTG-1];
  assign new_first_vel_x_o  = res_q[0];
  assign new_first_vel_y_o  = res_q[1];
  assign new_second_vel_x_o = res_q[2];
  assign new_second_vel_y_o = res_q[3];
  assign outcome_o          = outcome_q;

  a_exit_passes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && valid_q[NSTG-2] && (ctx_q[3].outcome != OUT_APPLIED) |=>
      (res_q[0] == $past(ctx_q[3].v1x)) && (res_q[1] == $past(ctx_q[3].v1y)))
    else $error("early exit changed the first velocity");

  a_no_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && valid_q[NSTG-2] && !ctx_q[3].two |=>
      (res_q[2] == $past(ctx_q[3].v2x)) && (res_q[3] == $past(ctx_q[3].v2y)))
    else $error("absent second particle changed velocity");

endmodule

### rtl/particle_contact_impulse_core.sv
// top level of the 2d particle contact impulse pipeline
`timescale 1ns / 1ps
//
//  channel  direction  handshake                  payload
//  -------  ---------  -------------------------  ------------------------------------
//  in       input      in_valid_i / in_stall_o    velocities, inverse masses, normal,
//                                                 bounce factor, second particle flag
//  out      output     out_valid_o / out_stall_i  resolved velocities, outcome
//
//  one item per cycle enters while not stalled, via 6 front stages (relative
//  velocity, dot product, early exit, delta product), 32 divider stages (one
//  range check, then one quotient bit per stage) and 5 back stages
//  reset clears only the valid bits; payload registers fill as items pass
//  a held result freezes the whole pipeline, and in_stall_o rises in the
//  same cycle, so no item is lost or repeated; bubbles move through freely
//
module particle_contact_impulse_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [pci_pkg::VEL_W-1:0]      first_vel_x_i,
  input  logic signed [pci_pkg::VEL_W-1:0]      first_vel_y_i,
  input  logic signed [pci_pkg::VEL_W-1:0]      second_vel_x_i,
  input  logic signed [pci_pkg::VEL_W-1:0]      second_vel_y_i,
  input  logic [pci_pkg::MASS_W-1:0]            first_inv_mass_i,
  input  logic [pci_pkg::MASS_W-1:0]            second_inv_mass_i,
  input  logic signed [pci_pkg::NRM_W-1:0]      normal_x_i,
  input  logic signed [pci_pkg::NRM_W-1:0]      normal_y_i,
  input  logic [pci_pkg::BNC_W-1:0]             bounce_factor_i,
  input  logic                                  has_second_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [pci_pkg::VEL_W-1:0]      new_first_vel_x_o,
  output logic signed [pci_pkg::VEL_W-1:0]      new_first_vel_y_o,
  output logic signed [pci_pkg::VEL_W-1:0]      new_second_vel_x_o,
  output logic signed [pci_pkg::VEL_W-1:0]      new_second_vel_y_o,
  output logic [1:0]                            outcome_o
);
  import pci_pkg::*;

  // dividend width: delta product of the negated separating velocity
  localparam int DIV_W = DOT_W - 1 - FRAC_BITS + K_W;

  logic               adv;
  pci_ctx_t           in_ctx;

  logic               front_valid;
  pci_ctx_t           front_ctx;
  logic [TOT_W-1:0]   front_total;
  logic [DIV_W-1:0]   front_dividend;

  logic               div_valid;
  pci_ctx_t           div_ctx;
  logic [IMP_W-1:0]   div_imp;

  // every stage moves unless a finished result is waiting to be taken
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  always_comb begin
    in_ctx.v1x     = first_vel_x_i;
    in_ctx.v1y     = first_vel_y_i;
    in_ctx.v2x     = second_vel_x_i;
    in_ctx.v2y     = second_vel_y_i;
    in_ctx.m1      = first_inv_mass_i;
    in_ctx.m2      = second_inv_mass_i;
    in_ctx.nx      = normal_x_i;
    in_ctx.ny      = normal_y_i;
    in_ctx.e       = bounce_factor_i;
    in_ctx.two     = has_second_i;
    in_ctx.outcome = OUT_APPLIED;  // settled once the dot product is known
  end

  // relative velocity, separating test, mass check and delta
  pci_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .valid_i    (in_valid_i),
    .ctx_i      (in_ctx),
    .valid_o    (front_valid),
    .ctx_o      (front_ctx),
    .total_o    (front_total),
    .dividend_o (front_dividend)
  );

  // impulse = delta over total inverse mass, saturated
  pci_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .valid_i    (front_valid),
    .ctx_i      (front_ctx),
    .total_i    (front_total),
    .dividend_i (front_dividend),
    .valid_o    (div_valid),
    .ctx_o      (div_ctx),
    .imp_o      (div_imp)
  );

  // impulse applied to each present particle, last stage is the output register
  pci_apply #(
    .FRAC_BITS (FRAC_BITS)
  ) u_apply (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .adv_i              (adv),
    .valid_i            (div_valid),
    .ctx_i              (div_ctx),
    .imp_i              (div_imp),
    .valid_o            (out_valid_o),
    .new_first_vel_x_o  (new_first_vel_x_o),
    .new_first_vel_y_o  (new_first_vel_y_o),
    .new_second_vel_x_o (new_second_vel_x_o),
    .new_second_vel_y_o (new_second_vel_y_o),
    .outcome_o          (outcome_o)
  );

endmodule

### dv/particle_contact_impulse_core_tb.sv
// testbench of the contact impulse core: directed and random contacts against a predictor
`timescale 1ns / 1ps
module particle_contact_impulse_core_tb;
  import pci_pkg::*;

  localparam int              FRAC          = 16;
  localparam longint unsigned ONE_Q         = 64'd1 << FRAC;
  localparam longint          IMP_LIMIT     = 64'h7FFF_FFFF;
  localparam int              RANDOM_ITEMS  = 800;
  localparam int              DRAIN_LIMIT   = 20000;
  localparam int              SETTLE_CYCLES = 60;   // pipeline is 43 deep

  // one contact as it enters the core
  typedef struct packed {
    logic signed [VEL_W-1:0]  v1x;
    logic signed [VEL_W-1:0]  v1y;
    logic signed [VEL_W-1:0]  v2x;
    logic signed [VEL_W-1:0]  v2y;
    logic [MASS_W-1:0]        m1;
    logic [MASS_W-1:0]        m2;
    logic signed [NRM_W-1:0]  nx;
    logic signed [NRM_W-1:0]  ny;
    logic [BNC_W-1:0]         e;
    logic                     has_second;
  } contact_t;

  // resolved velocities of one contact
  typedef struct packed {
    logic signed [VEL_W-1:0]  v1x;
    logic signed [VEL_W-1:0]  v1y;
    logic signed [VEL_W-1:0]  v2x;
    logic signed [VEL_W-1:0]  v2y;
    pci_outcome_e             outcome;
  } resolution_t;

  // receiver behavior, switched to a random mode whenever its run ends
  typedef enum logic [1:0] {RX_FLOW, RX_LIGHT, RX_HEAVY, RX_HOLD} rx_mode_e;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic signed [VEL_W-1:0]  first_vel_x_i;
  logic signed [VEL_W-1:0]  first_vel_y_i;
  logic signed [VEL_W-1:0]  second_vel_x_i;
  logic signed [VEL_W-1:0]  second_vel_y_i;
  logic [MASS_W-1:0]        first_inv_mass_i;
  logic [MASS_W-1:0]        second_inv_mass_i;
  logic signed [NRM_W-1:0]  normal_x_i;
  logic signed [NRM_W-1:0]  normal_y_i;
  logic [BNC_W-1:0]         bounce_factor_i;
  logic                     has_second_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic signed [VEL_W-1:0]  new_first_vel_x_o;
  logic signed [VEL_W-1:0]  new_first_vel_y_o;
  logic signed [VEL_W-1:0]  new_second_vel_x_o;
  logic signed [VEL_W-1:0]  new_second_vel_y_o;
  logic [1:0]               outcome_o;

  resolution_t expected_resolutions[$];  // one per accepted contact, oldest first
  resolution_t oldest_resolution;
  int          mismatch_count = 0;
  int          burst_left = 0;           // items left in the current sender burst
  rx_mode_e    rx_mode = RX_FLOW;
  int          rx_left = 0;

  particle_contact_impulse_core #(
    .FRAC_BITS(FRAC)
  ) uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .first_vel_x_i      (first_vel_x_i),
    .first_vel_y_i      (first_vel_y_i),
    .second_vel_x_i     (second_vel_x_i),
    .second_vel_y_i     (second_vel_y_i),
    .first_inv_mass_i   (first_inv_mass_i),
    .second_inv_mass_i  (second_inv_mass_i),
    .normal_x_i         (normal_x_i),
    .normal_y_i         (normal_y_i),
    .bounce_factor_i    (bounce_factor_i),
    .has_second_i       (has_second_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .new_first_vel_x_o  (new_first_vel_x_o),
    .new_first_vel_y_o  (new_first_vel_y_o),
    .new_second_vel_x_o (new_second_vel_x_o),
    .new_second_vel_y_o (new_second_vel_y_o),
    .outcome_o          (outcome_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // clamp a wide signed value into q16.16 range
  function automatic logic signed [VEL_W-1:0] clamp_q16(input longint x);
    if (x > IMP_LIMIT) begin
      return VEL_MAX;
    end
    if (x < -IMP_LIMIT - 1) begin
      return VEL_MIN;
    end
    return x[VEL_W-1:0];
  endfunction

  // expected velocities after one contact; every intermediate fits in 64 bits
  function automatic resolution_t resolve_contact(input contact_t c);
    longint          rel_x, rel_y, dot, sep, imp, px, py, m1s, m2s;
    longint unsigned tot, negsep, delta, quot;
    resolution_t     res;
    res.v1x     = c.v1x;
    res.v1y     = c.v1y;
    res.v2x     = c.v2x;
    res.v2y     = c.v2y;
    res.outcome = OUT_APPLIED;
    // relative velocity against scenery is just the first particle's
    rel_x = c.has_second ? longint'(c.v1x) - longint'(c.v2x) : longint'(c.v1x);
    rel_y = c.has_second ? longint'(c.v1y) - longint'(c.v2y) : longint'(c.v1y);
    dot   = rel_x * longint'(c.nx) + rel_y * longint'(c.ny);
    m1s   = longint'(c.m1);
    m2s   = longint'(c.m2);
    tot   = c.has_second ? m1s + m2s : m1s;
    // separation is tested on the full precision product, before the mass
    if (dot > 0) begin
      res.outcome = OUT_SEPARATING;
    end else if (tot == 0) begin
      res.outcome = OUT_INF_MASS;
    end else begin
      sep    = dot >>> FRAC;
      negsep = -sep;
      delta  = (negsep * (ONE_Q + c.e)) >> FRAC;
      quot   = (delta << FRAC) / tot;
      imp    = (quot > IMP_LIMIT) ? IMP_LIMIT : longint'(quot);
      px     = clamp_q16((longint'(c.nx) * imp) >>> FRAC);
      py     = clamp_q16((longint'(c.ny) * imp) >>> FRAC);
      res.v1x = clamp_q16(longint'(c.v1x) + ((px * m1s) >>> FRAC));
      res.v1y = clamp_q16(longint'(c.v1y) + ((py * m1s) >>> FRAC));
      // second particle is pushed the opposite way
      if (c.has_second) begin
        res.v2x = clamp_q16(longint'(c.v2x) + ((-(px * m2s)) >>> FRAC));
        res.v2y = clamp_q16(longint'(c.v2y) + ((-(py * m2s)) >>> FRAC));
      end
    end
    return res;
  endfunction

  function automatic contact_t make_contact(
    input logic signed [VEL_W-1:0] v1x, v1y, v2x, v2y,
    input logic [MASS_W-1:0] m1, m2,
    input logic signed [NRM_W-1:0] nx, ny,
    input logic [BNC_W-1:0] e,
    input logic has_second
  );
    contact_t c;
    c.v1x = v1x;
    c.v1y = v1y;
    c.v2x = v2x;
    c.v2y = v2y;
    c.m1  = m1;
    c.m2  = m2;
    c.nx  = nx;
    c.ny  = ny;
    c.e   = e;
    c.has_second = has_second;
    return c;
  endfunction

  // send one contact in bursts with random gaps; returns at the accepting edge
  task automatic send_contact(input contact_t c);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      // a third of the bursts follow the previous one without a gap
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    first_vel_x_i     <= c.v1x;
    first_vel_y_i     <= c.v1y;
    second_vel_x_i    <= c.v2x;
    second_vel_y_i    <= c.v2y;
    first_inv_mass_i  <= c.m1;
    second_inv_mass_i <= c.m2;
    normal_x_i        <= c.nx;
    normal_y_i        <= c.ny;
    bounce_factor_i   <= c.e;
    has_second_i      <= c.has_second;
    in_valid_i        <= 1'b1;
    // payload stays put while stalled
    do @(posedge clk_i); while (in_stall_o);
    expected_resolutions.push_back(resolve_contact(c));
  endtask

  task automatic compare_lane(input string lane, input logic signed [VEL_W-1:0] want, got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, lane, want, got);
      mismatch_count++;
    end
  endtask

  // field extremes, alternating bit patterns, head-on and saturating contacts
  task automatic test_extremes();
    send_contact(make_contact(VEL_MAX, VEL_MAX, VEL_MIN, VEL_MIN, '1, '1,
                              -18'sd131072, 18'sd131071, '1, 1'b1));
    send_contact(make_contact(VEL_MIN, VEL_MIN, VEL_MAX, VEL_MAX, '1, '0,
                              18'sd131071, 18'sd131071, '1, 1'b1));
    send_contact(make_contact(VEL_MAX, VEL_MAX, 0, 0, 31'd1, '0,
                              -18'sd65536, -18'sd65536, 17'd65536, 1'b0));
    send_contact(make_contact(VEL_MIN, VEL_MIN, 0, 0, '1, '1,
                              18'sd65536, 18'sd65536, '0, 1'b0));
    send_contact(make_contact(0, 0, 0, 0, 31'd1, 31'd1, 0, 0, '0, 1'b1));
    send_contact(make_contact(32'sd65536, -32'sd65536, -32'sd65536, 32'sd65536,
                              31'd65536, 31'd65536, -18'sd65536, 0, 17'd65536, 1'b1));
    send_contact(make_contact(VEL_MAX, VEL_MIN, VEL_MIN, VEL_MAX, '1, '1,
                              18'sd131071, -18'sd131072, '0, 1'b1));
    send_contact(make_contact(32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555,
                              31'h2AAA_AAAA, 31'h5555_5555, 18'h2AAAA, 18'h15555,
                              17'h15555, 1'b1));
    send_contact(make_contact(32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA,
                              31'h5555_5555, 31'h2AAA_AAAA, 18'h15555, 18'h2AAAA,
                              17'h0AAAA, 1'b1));
  endtask

  // separating velocity just above, at and just below zero
  task automatic test_separation_boundary();
    send_contact(make_contact(1, 0, 0, 0, 31'd65536, 0, 18'sd1, 0, '0, 1'b0));
    send_contact(make_contact(-1, 0, 0, 0, 31'd65536, 0, 18'sd1, 0, '0, 1'b0));
    send_contact(make_contact(32'sd65536, 0, 0, 0, 31'd65536, 0, 0, 18'sd65536, '0, 1'b0));
    send_contact(make_contact(32'sd98304, -32'sd12345, 32'sd98304, -32'sd12345,
                              31'd65536, 31'd32768, 18'sd46341, 18'sd46341, 17'd32768, 1'b1));
    send_contact(make_contact(0, 32'sd131072, 0, -32'sd65536, 31'd65536, 31'd65536,
                              0, 18'sd65536, 17'd65536, 1'b1));
  endtask

  // total inverse mass of zero, and zero mass on only one side
  task automatic test_infinite_mass();
    send_contact(make_contact(-32'sd65536, 0, 32'sd777, 32'sd888, '0, '1,
                              18'sd65536, 0, 17'd65536, 1'b0));
    send_contact(make_contact(-32'sd65536, 32'sd4096, 32'sd65536, 0, '0, '0,
                              18'sd65536, 0, 17'd32768, 1'b1));
    send_contact(make_contact(-32'sd65536, 32'sd4096, 32'sd65536, 0, '0, 31'd65536,
                              18'sd65536, 0, 17'd32768, 1'b1));
    // separation wins over infinite mass
    send_contact(make_contact(32'sd65536, 0, 0, 0, '0, '0, 18'sd65536, 0, '0, 1'b1));
  endtask

  // no second particle: its velocity and inverse mass must be ignored
  task automatic test_scenery_contact();
    send_contact(make_contact(-32'sd200000, 32'sd50000, 32'sd123456, -32'sd654321,
                              31'd131072, '1, 18'sd39322, 18'sd52429, 17'd49152, 1'b0));
    send_contact(make_contact(32'sd200000, 0, VEL_MIN, VEL_MAX, 31'd65536, 31'd65536,
                              18'sd65536, 0, '0, 1'b0));
    send_contact(make_contact(0, -32'sd300000, VEL_MAX, VEL_MIN, '0, 31'd65536,
                              0, 18'sd65536, 17'd65536, 1'b0));
  endtask

  // mostly physical contacts with random content, the rest raw bit patterns
  task automatic test_random_contacts();
    contact_t    c;
    resolution_t probe;
    int          shamt;
    int          na, nb;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        c.v1x = VEL_W'($urandom);
        c.v1y = VEL_W'($urandom);
        c.v2x = VEL_W'($urandom);
        c.v2y = VEL_W'($urandom);
        c.m1  = MASS_W'($urandom);
        c.m2  = MASS_W'($urandom);
        c.nx  = NRM_W'($urandom);
        c.ny  = NRM_W'($urandom);
        c.e   = BNC_W'($urandom);
        c.has_second = 1'($urandom);
      end else begin
        // velocity magnitude from tiny up to the full range
        case ($urandom_range(0, 3))
          0: shamt = 16;
          1: shamt = 10;
          2: shamt = 4;
          default: shamt = 0;
        endcase
        c.v1x = $signed($urandom) >>> shamt;
        c.v1y = $signed($urandom) >>> shamt;
        c.v2x = $signed($urandom) >>> shamt;
        c.v2y = $signed($urandom) >>> shamt;
        c.m1  = ($urandom_range(0, 9) == 0) ? '0 : MASS_W'($urandom_range(1, 32'h4_0000));
        c.m2  = ($urandom_range(0, 9) == 0) ? '0 : MASS_W'($urandom_range(1, 32'h4_0000));
        // unit normals: axes, diagonals and 3-4-5 directions
        case ($urandom_range(0, 4))
          0: begin na = 65536; nb = 0;     end
          1: begin na = 0;     nb = 65536; end
          2: begin na = 46341; nb = 46341; end
          3: begin na = 39322; nb = 52429; end
          default: begin na = 52429; nb = 39322; end
        endcase
        c.nx  = NRM_W'($urandom_range(0, 1) ? -na : na);
        c.ny  = NRM_W'($urandom_range(0, 1) ? -nb : nb);
        c.e   = BNC_W'($urandom_range(0, 65536));
        c.has_second = 1'($urandom_range(0, 1));
        // turn most separating contacts around so the impulse path dominates
        probe = resolve_contact(c);
        if ($urandom_range(0, 3) != 0 && probe.outcome == OUT_SEPARATING) begin
          c.nx = -c.nx;
          c.ny = -c.ny;
        end
      end
      send_contact(c);
    end
  endtask

  // receiver: free flow, light or heavy random stalls, or a solid hold
  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = (rx_mode == RX_HOLD) ? $urandom_range(1, 20) : $urandom_range(8, 80);
    end
    rx_left--;
    case (rx_mode)
      RX_FLOW:  out_stall_i <= 1'b0;
      RX_LIGHT: out_stall_i <= ($urandom_range(0, 4) == 0);
      RX_HEAVY: out_stall_i <= ($urandom_range(0, 2) != 0);
      default:  out_stall_i <= 1'b1;
    endcase
  end

  // every accepted result is matched against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_resolutions.size() == 0) begin
        $display("%0t: unexpected result, expected nothing, got outcome %0d",
                 $time, outcome_o);
        mismatch_count++;
      end else begin
        oldest_resolution = expected_resolutions.pop_front();
        compare_lane("new_first_vel_x", oldest_resolution.v1x, new_first_vel_x_o);
        compare_lane("new_first_vel_y", oldest_resolution.v1y, new_first_vel_y_o);
        compare_lane("new_second_vel_x", oldest_resolution.v2x, new_second_vel_x_o);
        compare_lane("new_second_vel_y", oldest_resolution.v2y, new_second_vel_y_o);
        if (outcome_o !== oldest_resolution.outcome) begin
          $display("%0t: outcome mismatch, expected %0d, got %0d",
                   $time, oldest_resolution.outcome, outcome_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : main_seq
    int drain_cycles;
    drain_cycles      = 0;
    rst_ni            = 1'b0;
    in_valid_i        = 1'b0;
    out_stall_i       = 1'b0;
    first_vel_x_i     = '0;
    first_vel_y_i     = '0;
    second_vel_x_i    = '0;
    second_vel_y_i    = '0;
    first_inv_mass_i  = '0;
    second_inv_mass_i = '0;
    normal_x_i        = '0;
    normal_y_i        = '0;
    bounce_factor_i   = '0;
    has_second_i      = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_extremes();
    test_separation_boundary();
    test_infinite_mass();
    test_scenery_contact();
    test_random_contacts();
    in_valid_i <= 1'b0;

    // let the pipeline drain, then watch a while for stray results
    while (expected_resolutions.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    if (expected_resolutions.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_resolutions.size());
      $display("Some tests failed");
    end else begin
      repeat (SETTLE_CYCLES) @(posedge clk_i);
      if (mismatch_count == 0) begin
        $display("All tests passed");
      end else begin
        $display("Some tests failed");
      end
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("%0t: run did not finish in time", $time);
    $display("Some tests failed");
    $finish;
  end

endmodule

### sim.f
rtl/pci_pkg.sv
rtl/pci_front.sv
rtl/pci_div.sv
rtl/pci_apply.sv
rtl/particle_contact_impulse_core.sv
dv/particle_contact_impulse_core_tb.sv
